// File: rtl/core/cubic_bezier_easing_solver_defines.svh
// ----------------------------------------------------------------------------
// cubic bezier easing solver assertion macros
// shared property forms for the solver's concurrent checks
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_EASING_SOLVER_DEFINES_SVH
`define CUBIC_BEZIER_EASING_SOLVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CBES_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CBES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cbes_pkg.sv
// ----------------------------------------------------------------------------
// cbes_pkg
// widths, fixed-point constants, sequencer codes and shared types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbes_pkg;

  // fixed-point format and newton iteration count
  localparam int FRAC_BITS = 16;
  localparam int MAX_STEPS = 8;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);

  // port widths
  localparam int PROG_W     = 17;
  localparam int CTRL_W     = 18;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // datapath width: every curve and slope term stays below 2^26 in magnitude
  localparam int MW = 28;

  // divider: quotients of 2^DIV_QBITS or more already push s into saturation
  localparam int DIV_QBITS = 19;
  localparam int DIV_W     = MW + FRAC_BITS + 2;
  localparam int DIV_CNT_W = $clog2(DIV_QBITS);
  localparam int QUOT_W    = DIV_QBITS + 2;

  // fixed-point constants
  localparam logic signed [MW-1:0]     ONE_W   = MW'(1 << FRAC_BITS);
  localparam logic signed [CTRL_W-1:0] S_INIT  = CTRL_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [CTRL_W-1:0] S_MAX   = CTRL_W'((2 << FRAC_BITS) - 1);
  localparam logic signed [CTRL_W-1:0] S_MIN   = CTRL_W'(-(2 << FRAC_BITS));
  localparam logic signed [CTRL_W-1:0] OUT_MAX = {1'b0, {(CTRL_W-1){1'b1}}};
  localparam logic signed [CTRL_W-1:0] OUT_MIN = {1'b1, {(CTRL_W-1){1'b0}}};

  // register reset values
  localparam logic signed [CTRL_W-1:0] CTRL0_RST = '0;
  localparam logic signed [CTRL_W-1:0] CTRL1_RST = CTRL_W'(1 << FRAC_BITS);
  localparam logic [THR_W-1:0]         THR_RST   = THR_W'(1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL0_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL0_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL1_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL1_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP    = CFG_IDX_W'(4);

  // top-level sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // evaluation micro-steps, at most one multiply issued per step
  typedef enum logic [3:0] {
    OP_SU   = 4'd0,   // s*u
    OP_SS   = 4'd1,   // s*s
    OP_SSU  = 4'd2,   // ss*u
    OP_B    = 4'd3,   // ssu*p1
    OP_SUU  = 4'd4,   // su*u
    OP_A    = 4'd5,   // suu*p0
    OP_C    = 4'd6,   // ss*s
    OP_UU   = 4'd7,   // u*u, curve value complete
    OP_DA   = 4'd8,   // uu*p0, residual check
    OP_DB   = 4'd9,   // su*(p1-p0)
    OP_DC   = 4'd10,  // ss*(1-p1)
    OP_DSUM = 4'd11   // slope value complete
  } eval_op_t;

  // divide request and response
  typedef struct packed {
    logic                 start;
    logic signed [MW-1:0] num;
    logic signed [MW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/cbes_mul.sv
// ----------------------------------------------------------------------------
// cbes_mul
// shared signed fixed-point multiplier, product floored and registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbes_mul (
  input  wire logic                          clk,
  input  wire logic signed [cbes_pkg::MW-1:0] a,
  input  wire logic signed [cbes_pkg::MW-1:0] b,
  output logic signed [cbes_pkg::MW-1:0]      q
);

  import cbes_pkg::*;

  logic signed [2*MW-1:0] prod;
  logic signed [MW-1:0]   q_r;

  // full product; dropping the low fraction bits floors toward minus infinity
  assign prod = a * b;

  always_ff @(posedge clk) begin
    q_r <= prod[FRAC_BITS+MW-1:FRAC_BITS];
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: rtl/core/cbes_div.sv
// ----------------------------------------------------------------------------
// cbes_div
// restoring divider for the newton quotient (f << frac) / df, one bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbes_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cbes_pkg::div_req_t req,
  output cbes_pkg::div_rsp_t      rsp
);

  import cbes_pkg::*;

  logic [MW-1:0]          num_abs;
  logic [MW-1:0]          den_abs;
  logic [DIV_W-1:0]       num_mag;
  logic [DIV_W-1:0]       den_mag;
  logic                   ge;
  logic [DIV_QBITS:0]     mag;

  logic [DIV_W-1:0]       rem_r;
  logic [DIV_W-1:0]       dvs_r;
  logic [DIV_QBITS-1:0]   quo_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   neg_r;
  logic                   ovf_r;
  logic                   run_r;
  logic                   done_r;

  // operand magnitudes
  assign num_abs = req.num[MW-1] ? MW'(-req.num) : MW'(req.num);
  assign den_abs = req.den[MW-1] ? MW'(-req.den) : MW'(req.den);
  assign num_mag = DIV_W'(num_abs) << FRAC_BITS;
  assign den_mag = DIV_W'(den_abs);

  // trial subtract
  assign ge = (rem_r >= dvs_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && (cnt_r == '0);
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_QBITS - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  // remainder, shifted divisor and quotient bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= num_mag;
      dvs_r <= den_mag << (DIV_QBITS - 1);
      quo_r <= '0;
      neg_r <= req.num[MW-1] ^ req.den[MW-1];
      ovf_r <= (num_mag >= (den_mag << DIV_QBITS));
    end else if (run_r) begin
      rem_r <= ge ? (rem_r - dvs_r) : rem_r;
      dvs_r <= dvs_r >> 1;
      quo_r <= {quo_r[DIV_QBITS-2:0], ge};
    end
  end

  // quotient truncated toward zero, magnitude capped at 2^DIV_QBITS
  assign mag = ovf_r ? {1'b1, {DIV_QBITS{1'b0}}} : {1'b0, quo_r};

  always_comb begin
    rsp.done = done_r;
    if (neg_r) begin
      rsp.quot = -$signed(QUOT_W'(mag));
    end else begin
      rsp.quot = $signed(QUOT_W'(mag));
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/cubic_bezier_easing_solver.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_solver
// maps progress t to the eased value of a cubic bezier timing curve
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall carries one progress word (unsigned Q1.16); the block
//   stalls its input from acceptance until the result sits in the output
//   register. out_valid/out_stall delivers one eased word (signed Q2.16).
//   cfg_valid/cfg_ready writes the control points and stop threshold; always
//   ready; the user must write it only while the block is idle (unchecked).
// sequencing:
//   one shared multiplier works through each newton step (curve, residual
//   check, slope), a check state tests the slope and a one-bit-a-cycle
//   divider forms the quotient. the solve ends early on a small residual or
//   flat slope, else after all 8 steps; the final y curve is then evaluated
//   and loaded into the output register; only then is the next word taken.
// reset:
//   rst_n is synchronous; control points return to (0,0) and (1,1), the
//   threshold to 1, and the output register empties.
// stall:
//   a word held by out_stall stays in place; a finished result waits in the
//   done state until the output register frees, then the input reopens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_easing_solver (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // progress input
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [cbes_pkg::PROG_W-1:0]         in_progress,
  // eased output
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [cbes_pkg::CTRL_W-1:0]       out_eased,
  // register writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cbes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cbes_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cbes_pkg::*;

  // configuration registers
  logic signed [CTRL_W-1:0] ctrl0_x_r;
  logic signed [CTRL_W-1:0] ctrl0_y_r;
  logic signed [CTRL_W-1:0] ctrl1_x_r;
  logic signed [CTRL_W-1:0] ctrl1_y_r;
  logic [THR_W-1:0]         thr_r;

  // sequencer and datapath registers
  state_t                   state_r, state_nxt;
  eval_op_t                 op_r, op_nxt;
  logic                     ymode_r, ymode_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [CTRL_W-1:0] s_r, s_nxt;
  logic [PROG_W-1:0]        t_r, t_nxt;
  logic signed [MW-1:0]     su_r, su_nxt;
  logic signed [MW-1:0]     ss_r, ss_nxt;
  logic signed [MW-1:0]     acc_r, acc_nxt;
  logic signed [MW-1:0]     f_r, f_nxt;
  logic signed [CTRL_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CTRL_W-1:0] out_eased_r, out_eased_nxt;

  // shared units
  logic signed [MW-1:0]     mul_a;
  logic signed [MW-1:0]     mul_b;
  logic signed [MW-1:0]     mq;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // derived operands
  logic signed [MW-1:0]     s_w;
  logic signed [MW-1:0]     u_w;
  logic signed [MW-1:0]     p0_w;
  logic signed [MW-1:0]     p1_w;
  logic signed [MW-1:0]     dp_w;
  logic signed [MW-1:0]     om_w;
  logic signed [MW-1:0]     t_w;
  logic signed [MW-1:0]     thr_w;
  logic signed [MW-1:0]     mq3;
  logic signed [MW-1:0]     mq6;
  logic signed [MW-1:0]     curve_val;
  logic signed [MW-1:0]     f_new;
  logic signed [MW-1:0]     f_abs;
  logic signed [MW-1:0]     df_abs;
  logic signed [CTRL_W-1:0] y_sat;
  logic signed [QUOT_W:0]   s_diff;
  logic signed [CTRL_W-1:0] s_upd;

  // register writes, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl0_x_r <= CTRL0_RST;
      ctrl0_y_r <= CTRL0_RST;
      ctrl1_x_r <= CTRL1_RST;
      ctrl1_y_r <= CTRL1_RST;
      thr_r     <= THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CTRL0_X: ctrl0_x_r <= $signed(cfg_data[CTRL_W-1:0]);
        CFG_CTRL0_Y: ctrl0_y_r <= $signed(cfg_data[CTRL_W-1:0]);
        CFG_CTRL1_X: ctrl1_x_r <= $signed(cfg_data[CTRL_W-1:0]);
        CFG_CTRL1_Y: ctrl1_y_r <= $signed(cfg_data[CTRL_W-1:0]);
        CFG_STOP:    thr_r     <= cfg_data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // operand preparation, x or y control points by mode
  assign s_w   = MW'(s_r);
  assign u_w   = ONE_W - s_w;
  assign p0_w  = ymode_r ? MW'(ctrl0_y_r) : MW'(ctrl0_x_r);
  assign p1_w  = ymode_r ? MW'(ctrl1_y_r) : MW'(ctrl1_x_r);
  assign dp_w  = p1_w - p0_w;
  assign om_w  = ONE_W - p1_w;
  assign t_w   = $signed({{(MW-PROG_W){1'b0}}, t_r});
  assign thr_w = $signed({{(MW-THR_W){1'b0}}, thr_r});

  // term scaling and sums
  assign mq3       = (mq <<< 1) + mq;
  assign mq6       = mq3 <<< 1;
  assign curve_val = acc_r + mq;
  assign f_new     = curve_val - t_w;
  assign f_abs     = f_r[MW-1] ? -f_r : f_r;
  assign df_abs    = acc_r[MW-1] ? -acc_r : acc_r;

  // output saturation
  always_comb begin
    if (curve_val > MW'(OUT_MAX)) begin
      y_sat = OUT_MAX;
    end else if (curve_val < MW'(OUT_MIN)) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = curve_val[CTRL_W-1:0];
    end
  end

  // newton update with parameter saturation
  assign s_diff = (QUOT_W+1)'(s_r) - (QUOT_W+1)'(div_rsp.quot);

  always_comb begin
    if (s_diff > (QUOT_W+1)'(S_MAX)) begin
      s_upd = S_MAX;
    end else if (s_diff < (QUOT_W+1)'(S_MIN)) begin
      s_upd = S_MIN;
    end else begin
      s_upd = s_diff[CTRL_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ymode_nxt     = ymode_r;
    step_nxt      = step_r;
    s_nxt         = s_r;
    t_nxt         = t_r;
    su_nxt        = su_r;
    ss_nxt        = ss_r;
    acc_nxt       = acc_r;
    f_nxt         = f_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_eased_nxt = out_eased_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = f_r;
    div_req.den   = acc_r;

    // output word taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          t_nxt     = in_progress;
          s_nxt     = S_INIT;
          step_nxt  = '0;
          op_nxt    = OP_SU;
          ymode_nxt = 1'b0;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        op_nxt = eval_op_t'(op_r + 4'd1);
        case (op_r)
          OP_SU: begin
            mul_a = s_w;
            mul_b = u_w;
          end
          OP_SS: begin
            mul_a  = s_w;
            mul_b  = s_w;
            su_nxt = mq;
          end
          OP_SSU: begin
            mul_a  = mq;
            mul_b  = u_w;
            ss_nxt = mq;
          end
          OP_B: begin
            mul_a = mq;
            mul_b = p1_w;
          end
          OP_SUU: begin
            mul_a   = su_r;
            mul_b   = u_w;
            acc_nxt = mq3;
          end
          OP_A: begin
            mul_a = mq;
            mul_b = p0_w;
          end
          OP_C: begin
            mul_a   = ss_r;
            mul_b   = s_w;
            acc_nxt = acc_r + mq3;
          end
          OP_UU: begin
            mul_a = u_w;
            mul_b = u_w;
            // curve value is complete this cycle
            if (ymode_r) begin
              res_nxt   = y_sat;
              state_nxt = ST_DONE;
            end else begin
              f_nxt = f_new;
            end
          end
          OP_DA: begin
            mul_a = mq;
            mul_b = p0_w;
            // residual small enough: evaluate y at the current s
            if (f_abs < thr_w) begin
              ymode_nxt = 1'b1;
              op_nxt    = OP_SU;
            end
          end
          OP_DB: begin
            mul_a   = su_r;
            mul_b   = dp_w;
            acc_nxt = mq3;
          end
          OP_DC: begin
            mul_a   = ss_r;
            mul_b   = om_w;
            acc_nxt = acc_r + mq6;
          end
          OP_DSUM: begin
            acc_nxt   = acc_r + mq3;
            state_nxt = ST_CHECK;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_CHECK: begin
        // flat slope ends the solve, otherwise divide
        if ((df_abs < thr_w) || (acc_r == '0)) begin
          ymode_nxt = 1'b1;
          op_nxt    = OP_SU;
          state_nxt = ST_EVAL;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          s_nxt     = s_upd;
          op_nxt    = OP_SU;
          state_nxt = ST_EVAL;
          if (step_r == STEP_W'(MAX_STEPS - 1)) begin
            ymode_nxt = 1'b1;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_eased_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_SU;
      ymode_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      ymode_r     <= ymode_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    t_r         <= t_nxt;
    su_r        <= su_nxt;
    ss_r        <= ss_nxt;
    acc_r       <= acc_nxt;
    f_r         <= f_nxt;
    res_r       <= res_nxt;
    out_eased_r <= out_eased_nxt;
  end

  // shared multiplier and divider
  cbes_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mq)
  );

  cbes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ports
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_eased = out_eased_r;

  // checks
  `include "cubic_bezier_easing_solver_defines.svh"

  `CBES_ASSERT_NEXT(a_accept_starts_eval, in_valid && !in_stall, state_r == ST_EVAL && op_r == OP_SU && !ymode_r, "accepted word did not start x evaluation")
  `CBES_ASSERT_IMPLIES(a_div_done_in_div, div_rsp.done, state_r == ST_DIV, "divider finished outside divide state")
  `CBES_ASSERT_IMPLIES(a_step_bound, state_r != ST_IDLE, step_r < STEP_W'(MAX_STEPS), "newton step count out of range")
  `CBES_ASSERT_NEXT(a_done_loads_out, state_r == ST_DONE && !(out_valid_r && out_stall), out_valid_r && state_r == ST_IDLE, "finished result not loaded into output")

endmodule

`default_nettype wire

// File: sim/cbes_eased_checker.sv
// ----------------------------------------------------------------------------
// cbes_eased_checker
// watches the progress, eased and register channels of the easing solver,
// solves each accepted progress word on its own copy of the control points
// and compares every eased word against the oldest outstanding prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbes_eased_checker
  import cbes_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [PROG_W-1:0]        in_progress,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [CTRL_W-1:0] out_eased,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       n_pending
);

  localparam longint FX_ONE = longint'(1) << FRAC_BITS;

  typedef struct {
    logic [PROG_W-1:0] progress;
    logic [CTRL_W-1:0] eased;
  } eased_due_t;

  // shadow of the control points and stop threshold
  logic signed [CTRL_W-1:0] px0, py0, px1, py1;
  logic [THR_W-1:0]         stop_eps;

  eased_due_t eased_due[$];
  int         bad_total = 0;

  initial begin
    fail_count = 0;
    n_pending  = 0;
  end

  // product floored back to the fixed-point grid
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fx_mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint fx_clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one coordinate of the bezier at parameter s
  function automatic longint bez_point(input longint s, input longint p0, input longint p1);
    longint u, a, b, c;
    u = FX_ONE - s;
    a = fx_mul(fx_mul(fx_mul(s, u), u), p0);
    b = fx_mul(fx_mul(fx_mul(s, s), u), p1);
    c = fx_mul(fx_mul(s, s), s);
    return 3 * a + 3 * b + c;
  endfunction

  // exact derivative of that coordinate
  function automatic longint bez_slope(input longint s, input longint p0, input longint p1);
    longint u, a, b, c;
    u = FX_ONE - s;
    a = fx_mul(fx_mul(u, u), p0);
    b = fx_mul(fx_mul(s, u), p1 - p0);
    c = fx_mul(fx_mul(s, s), FX_ONE - p1);
    return 3 * a + 6 * b + 3 * c;
  endfunction

  // newton solve of x(s) = t, then y(s) saturated to the output range
  function automatic logic [CTRL_W-1:0] solve_eased(input logic [PROG_W-1:0] progress);
    longint t, s, f, df, y, eps, x0, x1;
    t   = longint'(progress);
    eps = longint'(stop_eps);
    x0  = longint'(px0);
    x1  = longint'(px1);
    s   = FX_ONE / 2;
    for (int k = 0; k < MAX_STEPS; k++) begin
      f = bez_point(s, x0, x1) - t;
      if (fx_mag(f) < eps) break;
      df = bez_slope(s, x0, x1);
      if (fx_mag(df) < eps || df == 0) break;
      s = fx_clamp(s - (f * FX_ONE) / df, longint'(S_MIN), longint'(S_MAX));
    end
    y = fx_clamp(bez_point(s, longint'(py0), longint'(py1)),
                 longint'(OUT_MIN), longint'(OUT_MAX));
    return CTRL_W'(y);
  endfunction

  always @(posedge clk) begin
    eased_due_t due;
    if (!rst_n) begin
      px0      = CTRL0_RST;
      py0      = CTRL0_RST;
      px1      = CTRL1_RST;
      py1      = CTRL1_RST;
      stop_eps = THR_RST;
      eased_due.delete();
    end else begin
      // eased word leaving the block
      if (out_valid && !out_stall) begin
        if (eased_due.size() == 0) begin
          if (bad_total < 10)
            $display("%0t: eased word %0d with nothing outstanding", $realtime,
                     out_eased);
          bad_total++;
        end else begin
          due = eased_due.pop_front();
          if (out_eased !== due.eased) begin
            if (bad_total < 10)
              $display("%0t: progress %0d eased expected %0d got %0d", $realtime,
                       due.progress, $signed(due.eased), out_eased);
            bad_total++;
          end
        end
      end

      // progress word taken in
      if (in_valid && !in_stall) begin
        due.progress = in_progress;
        due.eased    = solve_eased(in_progress);
        eased_due.push_back(due);
      end

      // register write, unmapped indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CTRL0_X: px0 = $signed(cfg_data[CTRL_W-1:0]);
          CFG_CTRL0_Y: py0 = $signed(cfg_data[CTRL_W-1:0]);
          CFG_CTRL1_X: px1 = $signed(cfg_data[CTRL_W-1:0]);
          CFG_CTRL1_Y: py1 = $signed(cfg_data[CTRL_W-1:0]);
          CFG_STOP:    stop_eps = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
    n_pending  <= eased_due.size();
    fail_count <= bad_total;
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the easing solver with directed and random progress words across
// many control point and threshold settings, with bursty input and a
// patterned output stall; the checker beside the block does the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cbes_pkg::*;

  localparam int RANDOM_WORDS   = 1700;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = CFG_IDX_W'(CFG_STOP + 1);

  typedef enum {STALL_NONE, STALL_SPOTTY, STALL_BLOCKS} stall_mode_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [PROG_W-1:0]        in_progress = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CTRL_W-1:0] out_eased;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_CTRL0_X;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int fail_count;
  int n_pending;

  // sender burst shape
  int burst_left = 0;
  bit gaps_on    = 1'b0;
  int gap_max    = 1;

  cubic_bezier_easing_solver dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_progress (in_progress),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_eased   (out_eased),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  cbes_eased_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_progress (in_progress),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_eased   (out_eased),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .n_pending   (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output stall: stretches of no stall, scattered stalls and long blocks
  stall_mode_t stall_mode = STALL_NONE;
  int          stretch_left = 0;
  int          hold_left = 0;
  bit          hold_val = 1'b0;

  always @(posedge clk) begin
    if (stretch_left == 0) begin
      stall_mode   = stall_mode_t'($urandom_range(0, 2));
      stretch_left = $urandom_range(50, 600);
    end
    stretch_left--;
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_SPOTTY: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (hold_left == 0) begin
          hold_left = $urandom_range(1, 40);
          hold_val  = ~hold_val;
        end
        hold_left--;
        out_stall <= hold_val;
      end
    endcase
  end

  // watchdog on cycles without any accepted word
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one register write, returns in the cycle after the handshake
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_curve(input int x0, input int y0, input int x1, input int y1,
                             input int eps);
    cfg_write(CFG_CTRL0_X, CFG_DATA_W'(x0));
    cfg_write(CFG_CTRL0_Y, CFG_DATA_W'(y0));
    cfg_write(CFG_CTRL1_X, CFG_DATA_W'(x1));
    cfg_write(CFG_CTRL1_Y, CFG_DATA_W'(y1));
    cfg_write(CFG_STOP, CFG_DATA_W'(eps));
  endtask

  // one progress word, with a random gap before each new burst when gaps are on
  task automatic send_progress(input logic [PROG_W-1:0] p);
    if (burst_left == 0) begin
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid    <= 1'b1;
    in_progress <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // stop sending and wait for every eased word to come back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_ctrl();
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'(OUT_MIN);
      1:       return CFG_DATA_W'(OUT_MAX);
      2, 3, 4: return CFG_DATA_W'($urandom_range(0, 65536));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_eps();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(16'hFFFF);
      2:       return CFG_DATA_W'(1);
      3:       return CFG_DATA_W'($urandom_range(0, 64));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [PROG_W-1:0] pick_progress();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PROG_W'(65536);
      2:       return PROG_W'($urandom_range(65537, 131071));
      default: return PROG_W'($urandom_range(0, 65536));
    endcase
  endfunction

  initial begin
    int sent;
    int n_words;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset curve: ends of the range, midpoint, above one, alternating bits
    send_progress(PROG_W'(0));
    send_progress(PROG_W'(65536));
    send_progress(PROG_W'(32768));
    send_progress(PROG_W'(1));
    send_progress(PROG_W'(65535));
    send_progress(PROG_W'(131071));
    send_progress(PROG_W'(17'h15555));
    send_progress(PROG_W'(17'h0AAAA));
    drain();

    // slope exactly zero at the start point, with a zero threshold
    write_curve(65536, 131071, 0, -131072, 0);
    send_progress(PROG_W'(16384));
    send_progress(PROG_W'(49152));
    send_progress(PROG_W'(65536));
    drain();

    // extreme control points: parameter and output saturation
    write_curve(-131072, 131071, 131071, 131071, 0);
    send_progress(PROG_W'(0));
    send_progress(PROG_W'(65536));
    send_progress(PROG_W'(131071));
    send_progress(PROG_W'(40000));
    drain();

    // widest threshold stops on the residual; unmapped writes change nothing
    write_curve(16384, 6554, 16384, 65536, 65535);
    for (int k = CFG_UNMAPPED_LO; k < (1 << CFG_IDX_W); k++)
      cfg_write(CFG_IDX_W'(k), '1);
    send_progress(PROG_W'(20000));
    send_progress(PROG_W'(100000));
    drain();

    // random phases, each with its own settings and sender shape
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_CTRL0_X, pick_ctrl());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_CTRL0_Y, pick_ctrl());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_CTRL1_X, pick_ctrl());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_CTRL1_Y, pick_ctrl());
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_STOP, pick_eps());
      if ($urandom_range(0, 7) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
      gaps_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 2))
        0:       gap_max = 2;
        1:       gap_max = 8;
        default: gap_max = 40;
      endcase
      n_words = $urandom_range(20, 120);
      repeat (n_words) send_progress(pick_progress());
      sent += n_words;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && n_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
